// File: rtl/core/depth_tested_pixel_buffer_assert.svh
// Assertion macros for the depth-tested pixel buffer.
// Included by the top level; depends on nothing else.
`ifndef DEPTH_TESTED_PIXEL_BUFFER_ASSERT_SVH
`define DEPTH_TESTED_PIXEL_BUFFER_ASSERT_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define DTPB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel buffer check failed");

// Antecedent in a cycle implies consequent in the next cycle.
`define DTPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel buffer check failed");

`endif

// File: rtl/core/dtpb_pkg.sv
// Shared types and constants of the depth-tested pixel buffer.
// Used by dtpb_addr and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dtpb_pkg;

  localparam int DTPB_MAX_WIDTH  = 256;
  localparam int DTPB_MAX_HEIGHT = 256;

  localparam int COORD_W = 16;
  localparam int DEPTH_W = 16;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int SIZE_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_DEPTH     = 2'd2;

  localparam logic [SIZE_W-1:0]         RESET_SCREEN_WIDTH  = 9'd256;
  localparam logic [SIZE_W-1:0]         RESET_SCREEN_HEIGHT = 9'd256;
  localparam logic signed [DEPTH_W-1:0] RESET_FAR_DEPTH     = -16'sd256;

  localparam logic ACTION_PLOT = 1'b0;
  localparam logic ACTION_SCAN = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } dtpb_state_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DEPTH_W-1:0] depth_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [SIZE_W-1:0]         size_t;

endpackage

`default_nettype wire

// File: rtl/core/dtpb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dtpb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/dtpb_addr.sv
// Screen range check and pixel address of one beat's coordinates.
// Depends on dtpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtpb_addr #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ADDR_W     = 16
) (
  input  wire dtpb_pkg::coord_t  x,
  input  wire dtpb_pkg::coord_t  y,
  input  wire dtpb_pkg::size_t   screen_width,
  input  wire dtpb_pkg::size_t   screen_height,
  output logic                   hit,
  output logic [ADDR_W-1:0]      addr
);
  import dtpb_pkg::*;

  localparam logic [COORD_W-1:0] MW = COORD_W'(MAX_WIDTH);
  localparam logic [COORD_W-1:0] MH = COORD_W'(MAX_HEIGHT);

  logic [COORD_W-1:0] sw_ext;
  logic [COORD_W-1:0] sh_ext;
  logic [COORD_W-1:0] eff_w;
  logic [COORD_W-1:0] eff_h;
  logic [COORD_W-1:0] x_mag;
  logic [COORD_W-1:0] y_mag;
  logic [31:0]        lin;

  always_comb begin
    sw_ext = COORD_W'(screen_width);
    sh_ext = COORD_W'(screen_height);
    eff_w  = (sw_ext > MW) ? MW : sw_ext;
    eff_h  = (sh_ext > MH) ? MH : sh_ext;
    x_mag  = {1'b0, x[COORD_W-2:0]};
    y_mag  = {1'b0, y[COORD_W-2:0]};
    hit    = !x[COORD_W-1] && !y[COORD_W-1] && (x_mag < eff_w) && (y_mag < eff_h);
    lin    = 32'(x_mag) * 32'(MAX_HEIGHT) + 32'(y_mag);
    addr   = lin[ADDR_W-1:0];
  end

endmodule

`default_nettype wire

// File: rtl/core/depth_tested_pixel_buffer.sv
// Top level of the depth-tested pixel buffer: configuration, control and both stores.
// Depends on dtpb_pkg, dtpb_addr, dtpb_ram and depth_tested_pixel_buffer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "depth_tested_pixel_buffer_assert.svh"

// After reset the block sweeps both stores to black and to the reset far depth, one
// pixel per cycle; in_ready stays low during that pass while configuration writes are
// taken as usual. Each accepted beat then issues the read of both stores, and in the
// UPDATE state that follows the block tests the depth and writes a winning plot back,
// or clears a scanned on-screen pixel to black and the configured far depth; no new
// beat is taken until it is through. A scan-out result sits in an output register, so
// a stalled consumer holds the block only when a second scan-out result is ready.
module depth_tested_pixel_buffer #(
  parameter int MAX_WIDTH  = dtpb_pkg::DTPB_MAX_WIDTH,
  parameter int MAX_HEIGHT = dtpb_pkg::DTPB_MAX_HEIGHT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [dtpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dtpb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_action,
  input  wire dtpb_pkg::coord_t                    in_x,
  input  wire dtpb_pkg::coord_t                    in_y,
  input  wire dtpb_pkg::depth_t                    in_depth,
  input  wire logic [dtpb_pkg::CHAN_W-1:0]         in_red,
  input  wire logic [dtpb_pkg::CHAN_W-1:0]         in_green,
  input  wire logic [dtpb_pkg::CHAN_W-1:0]         in_blue,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [7:0]                               out_x,
  output logic [7:0]                               out_y,
  output logic                                     out_drawn,
  output logic [dtpb_pkg::CHAN_W-1:0]              out_red,
  output logic [dtpb_pkg::CHAN_W-1:0]              out_green,
  output logic [dtpb_pkg::CHAN_W-1:0]              out_blue
);
  import dtpb_pkg::*;

  localparam int PIX_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIX_COUNT - 1);

  dtpb_state_t state_r, state_nxt;

  size_t  screen_width_r, screen_height_r;
  depth_t far_depth_r;

  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic              act_r;
  logic              hit_r;
  logic              plot_ok_r;
  logic [ADDR_W-1:0] addr_r;
  depth_t            depth_r;
  color_t            color_r;
  logic [7:0]        x_r, y_r;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_x_r, out_y_r;
  color_t            out_color_r;

  logic              accept;
  logic              hit;
  logic [ADDR_W-1:0] addr;
  logic              depth_ok;

  color_t            color_rd;
  logic [DEPTH_W-1:0] depth_rd;
  logic              scan_hit;
  logic              plot_wins;
  logic              out_free;
  logic              proceed;
  logic              upd_go;
  logic              clr_done;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  color_t            color_wd;
  depth_t            depth_wd;

  dtpb_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_addr (
    .x             (in_x),
    .y             (in_y),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .hit           (hit),
    .addr          (addr)
  );

  dtpb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PIX_COUNT),
    .AW    (ADDR_W)
  ) u_color_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (color_wd),
    .re    (accept),
    .raddr (addr),
    .rdata (color_rd)
  );

  dtpb_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (PIX_COUNT),
    .AW    (ADDR_W)
  ) u_depth_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (depth_wd),
    .re    (accept),
    .raddr (addr),
    .rdata (depth_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RESET_SCREEN_WIDTH;
      screen_height_r <= RESET_SCREEN_HEIGHT;
      far_depth_r     <= RESET_FAR_DEPTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[SIZE_W-1:0];
        CFG_FAR_DEPTH:     far_depth_r     <= depth_t'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    accept    = in_valid && in_ready;
    depth_ok  = in_depth[DEPTH_W-1] && (in_depth > far_depth_r);
    scan_hit  = (act_r == ACTION_SCAN) && hit_r;
    plot_wins = (act_r == ACTION_PLOT) && plot_ok_r && ($signed(depth_rd) < depth_r);
    out_free  = !out_valid_r || out_ready;
    proceed   = !scan_hit || out_free;
    clr_done  = (clr_addr_r == LAST_ADDR);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_UPDATE;
      ST_UPDATE: if (proceed) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    upd_go    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    color_wd  = '0;
    depth_wd  = far_depth_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        depth_wd  = RESET_FAR_DEPTH;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_UPDATE: begin
        upd_go = proceed;
        mem_we = proceed && (scan_hit || plot_wins);
        if (!scan_hit) begin
          color_wd = color_r;
          depth_wd = depth_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    if (state_r == ST_CLEAR && !clr_done) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (upd_go && scan_hit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= in_action;
      hit_r     <= hit;
      plot_ok_r <= hit && depth_ok;
      addr_r    <= addr;
      depth_r   <= in_depth;
      color_r   <= {in_red, in_green, in_blue};
      x_r       <= in_x[7:0];
      y_r       <= in_y[7:0];
    end
    if (upd_go && scan_hit) begin
      out_x_r     <= x_r;
      out_y_r     <= y_r;
      out_color_r <= color_rd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_drawn = (out_color_r != '0);
  assign out_red   = out_color_r[3*CHAN_W-1:2*CHAN_W];
  assign out_green = out_color_r[2*CHAN_W-1:CHAN_W];
  assign out_blue  = out_color_r[CHAN_W-1:0];

  `DTPB_ASSERT_SAME(a_no_accept_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_ready)
  `DTPB_ASSERT_NEXT(a_accept_to_update, clk, rst_n, accept, state_r == ST_UPDATE)
  `DTPB_ASSERT_SAME(a_result_from_update, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_UPDATE)
  `DTPB_ASSERT_SAME(a_write_not_idle, clk, rst_n, mem_we, state_r != ST_IDLE)

endmodule

`default_nettype wire
